// ===== sv/oat_pkg.sv =====
`default_nettype none

package oat_pkg;

    // table geometry
    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int HART_BITS = 8;

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int KEY_BITS = (TAG_BITS > HART_BITS) ? TAG_BITS : HART_BITS;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [HART_BITS-1:0] hart;
    } t_entry;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        logic [IDX_BITS-1:0] raddr;
        t_entry              wdata;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== sv/oat_store.sv =====
`default_nettype none

module oat_store (
    input  wire logic              i_clk,
    input  wire oat_pkg::t_mem_req i_req,
    output oat_pkg::t_entry        o_rd
);
    import oat_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// ===== sv/ordered_action_table.sv =====
`default_nettype none

// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_op, i_action_tag, i_hart_id
// result    out        o_valid / i_ready   o_status, o_found_tag, o_entry_count
//
// push, rejected requests and requests on an empty table go from idle straight to
// the finish state, which loads the result register; a remove that hits scans and
// then compacts, any other remove or lookup only scans: the table sits in one
// memory with a single registered read port, so the scan and the compaction move
// one entry per cycle, and the scan checks each entry in the one shared comparator
// one request is worked at a time; o_ready is high only in the idle state
// reset (synchronous, active low) empties the table and drops any pending result
// a stalled result waits in the output register while the next request is taken

module ordered_action_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_action_tag,
    input  wire logic [7:0]  i_hart_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_found_tag,
    output logic [4:0]       o_entry_count
);
    import oat_pkg::*;

    // sequencer and working registers
    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic [CNT_BITS-1:0]   r_count, n_count;
    t_status               r_status, n_status;
    logic [TAG_BITS-1:0]   r_found, n_found;

    // result register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [TAG_BITS-1:0]   r_out_found, n_out_found;
    logic [CNT_BITS-1:0]   r_out_count, n_out_count;

    t_mem_req              w_mem_req;
    t_entry                w_rd;

    logic                  w_take;
    logic                  w_slot_free;
    logic [TAG_BITS-1:0]   w_in_tag;
    logic [HART_BITS-1:0]  w_in_hart;
    logic                  w_scan_start;
    logic [CNT_BITS-1:0]   w_idx_inc;
    logic                  w_last;
    logic                  w_shift_more;
    logic [KEY_BITS-1:0]   w_cand;
    logic                  w_hit;

    oat_store u_store (
        .i_clk (i_clk),
        .i_req (w_mem_req),
        .o_rd  (w_rd)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign w_take      = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;

    assign w_in_tag  = i_action_tag[TAG_BITS-1:0];
    assign w_in_hart = i_hart_id[HART_BITS-1:0];

    // remove with a real tag, or lookup, walks the table if it is not empty
    assign w_scan_start = w_take && (r_count != '0)
                          && (((i_op == OP_REMOVE) && (w_in_tag != '0))
                              || (i_op == OP_LOOKUP));

    assign w_idx_inc    = r_idx + CNT_BITS'(1);
    assign w_last       = (w_idx_inc == r_count);
    assign w_shift_more = (w_idx_inc < r_count);

    // shared comparator: tag for remove, hart for lookup
    assign w_cand = (r_op == OP_REMOVE) ? KEY_BITS'(w_rd.tag) : KEY_BITS'(w_rd.hart);
    assign w_hit  = (w_cand == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_scan_start) begin
                    n_state = S_SCAN;
                end else if (w_take) begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_op == OP_REMOVE) ? S_SHIFT : S_FINISH;
                end else if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!w_shift_more) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory port
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_count      = r_count;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        w_mem_req    = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // first entry is fetched while the request is taken
                w_mem_req.raddr = '0;
                if (w_take) begin
                    n_op    = (i_op == OP_REMOVE) ? OP_REMOVE : OP_LOOKUP;
                    n_key   = (i_op == OP_REMOVE) ? KEY_BITS'(w_in_tag)
                                                  : KEY_BITS'(w_in_hart);
                    n_idx   = '0;
                    n_found = '0;
                    case (i_op)
                        OP_PUSH: begin
                            if (w_in_tag == '0) begin
                                n_status = ST_INVALID;
                            end else if (r_count == CNT_BITS'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                // append at the tail
                                w_mem_req.we         = 1'b1;
                                w_mem_req.waddr      = IDX_BITS'(r_count);
                                w_mem_req.wdata.tag  = w_in_tag;
                                w_mem_req.wdata.hart = w_in_hart;
                                n_count              = r_count + CNT_BITS'(1);
                                n_status             = ST_OK;
                            end
                        end
                        OP_REMOVE: begin
                            n_status = (w_in_tag == '0) ? ST_INVALID : ST_NOT_FOUND;
                        end
                        OP_LOOKUP: begin
                            n_status = ST_NOT_FOUND;
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read data holds entry r_idx; fetch the next one
                w_mem_req.raddr = IDX_BITS'(w_idx_inc);
                if (w_hit) begin
                    n_status = ST_OK;
                    if (r_op == OP_LOOKUP) begin
                        n_found = w_rd.tag;
                    end
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_SHIFT: begin
                // read data holds entry r_idx + 1, moved down into r_idx
                w_mem_req.raddr = IDX_BITS'(r_idx + CNT_BITS'(2));
                if (w_shift_more) begin
                    w_mem_req.we    = 1'b1;
                    w_mem_req.waddr = IDX_BITS'(r_idx);
                    w_mem_req.wdata = w_rd;
                    n_idx           = w_idx_inc;
                end else begin
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = r_count;
                end
            end
            default: begin
                w_mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_tag   = 16'(r_out_found);
    assign o_entry_count = 5'(r_out_count);

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count above depth");

    // writes come only from an accepted push or the compaction pass
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.we |-> ((r_state == S_SHIFT) || ((r_state == S_IDLE) && i_valid)))
        else $error("table write outside push or compaction");

    // count moves only on push or at the end of compaction
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (r_state != S_SHIFT)) |=> $stable(r_count))
        else $error("entry count changed during scan or finish");

    // compaction stays inside the filled part of the table
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx < r_count))
        else $error("compaction index beyond count");

    // a returned tag only comes with a successful lookup
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_found_tag != '0)) |-> (o_status == ST_OK))
        else $error("found tag with failing status");

endmodule

`default_nettype wire
